// ===== rtl/hsv2rgb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types and fixed-point constants of the hsv to rgb converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // channel and hue formats
  localparam int CHANNEL_BITS = 8;
  localparam int HUE_BITS     = 15;
  localparam int HUE_SECTOR   = 3840;   // 60 degrees in 1/64 degree units
  localparam int HUE_FULL     = 23040;  // 360 degrees
  localparam int SECTORS      = 6;
  localparam int SEC_BITS     = $clog2(SECTORS);
  localparam int REM_BITS     = $clog2(HUE_SECTOR);
  localparam int W_BITS       = $clog2(HUE_SECTOR + 1);

  // level arithmetic: level = floor((v*(DEN - s*w) + ofs) / DEN)
  localparam longint unsigned CHAN_MAX = (64'd1 << CHANNEL_BITS) - 64'd1;
  localparam longint unsigned DEN      = CHAN_MAX * HUE_SECTOR;
  localparam int              DEN_BITS = $clog2(DEN + 64'd1);
  localparam longint unsigned QT_OFS   = DEN / 2;
  localparam longint unsigned P_OFS    = (CHAN_MAX / 2) * HUE_SECTOR;
  localparam longint unsigned X_MAX    = CHAN_MAX * DEN + QT_OFS;
  localparam int              X_BITS   = $clog2(X_MAX + 64'd1);
  // truncated reciprocal, quotient estimate is low by at most one
  localparam longint unsigned RECIP      = (64'd1 << X_BITS) / DEN;
  localparam int              RECIP_BITS = $clog2(RECIP + 64'd1);
  localparam int              PROD_BITS  = X_BITS + RECIP_BITS;

  // stream widths, whole bytes
  localparam int IN_TDATA_BITS  = ((HUE_BITS + 2 * CHANNEL_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((3 * CHANNEL_BITS + 7) / 8) * 8;

  // hue sector, named by the color at its start
  typedef enum logic [SEC_BITS-1:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } hsv2rgb_sec_t;

  // per-request control that rides beside the level lanes
  typedef struct packed {
    hsv2rgb_sec_t            sector;
    logic                    black;
    logic [CHANNEL_BITS-1:0] bri;
  } hsv2rgb_ctl_t;

  // stage load enables of a level lane
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } hsv2rgb_ld_t;

endpackage
`default_nettype wire

// ===== rtl/hsv2rgb_sector.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_sector
// First stage: folds a full turn to zero, flags hues beyond a turn, and
// splits the hue into a 60 degree sector and the remainder inside it.
// ----------------------------------------------------------------------------
module hsv2rgb_sector
  import hsv2rgb_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    ld,
  input  wire logic [HUE_BITS-1:0]     hue,
  input  wire logic [CHANNEL_BITS-1:0] sat,
  input  wire logic [CHANNEL_BITS-1:0] bri,
  output hsv2rgb_ctl_t                 ctl_r,
  output logic [REM_BITS-1:0]          rem_r,
  output logic [CHANNEL_BITS-1:0]      sat_r
);

  logic [HUE_BITS-1:0] hue_eff;
  logic [HUE_BITS-1:0] base;
  logic [SEC_BITS-1:0] cnt;
  logic                over;
  hsv2rgb_ctl_t        ctl_nxt;
  logic [REM_BITS-1:0] rem_nxt;

  // full turn maps to zero, anything past it is black
  always_comb begin
    over    = (hue > HUE_BITS'(HUE_FULL));
    hue_eff = (hue == HUE_BITS'(HUE_FULL)) ? '0 : hue;
  end

  // sector by parallel threshold compares
  always_comb begin
    cnt  = '0;
    base = '0;
    for (int k = 1; k < SECTORS; k++) begin
      if (hue_eff >= HUE_BITS'(k * HUE_SECTOR)) begin
        cnt  = SEC_BITS'(k);
        base = HUE_BITS'(k * HUE_SECTOR);
      end
    end
  end

  always_comb begin
    rem_nxt        = REM_BITS'(hue_eff - base);
    ctl_nxt.sector = hsv2rgb_sec_t'(cnt);
    ctl_nxt.black  = over;
    ctl_nxt.bri    = bri;
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      ctl_r <= ctl_nxt;
      rem_r <= rem_nxt;
      sat_r <= sat;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/hsv2rgb_level.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_level
// One level lane: forms v*(1 - s*w) in exact fixed point and rounds it to a
// channel code through a reciprocal multiply and a single correction step.
// ----------------------------------------------------------------------------
module hsv2rgb_level
  import hsv2rgb_pkg::*;
(
  input  wire logic                    clk,
  input  wire hsv2rgb_ld_t             ld,
  input  wire logic [CHANNEL_BITS-1:0] sat,
  input  wire logic [CHANNEL_BITS-1:0] bri,
  input  wire logic [W_BITS-1:0]       weight,
  input  wire logic [X_BITS-1:0]       ofs,
  output logic [CHANNEL_BITS-1:0]      level
);

  logic [DEN_BITS-1:0]     a_r;
  logic [CHANNEL_BITS-1:0] v2_r;
  logic [DEN_BITS-1:0]     d_r;
  logic [CHANNEL_BITS-1:0] v3_r;
  logic [X_BITS-1:0]       x_r;
  logic [X_BITS-1:0]       x5_r;
  logic [CHANNEL_BITS-1:0] q5_r;
  logic [X_BITS-1:0]       x6_r;
  logic [CHANNEL_BITS-1:0] q6_r;
  logic [X_BITS-1:0]       qd_r;
  logic [PROD_BITS-1:0]    prod;
  logic [X_BITS-1:0]       diff;

  // stage 2: s times hue weight
  always_ff @(posedge clk) begin
    if (ld.s2) begin
      a_r  <= DEN_BITS'(sat) * DEN_BITS'(weight);
      v2_r <= bri;
    end
  end

  // stage 3: one minus s*w, scaled by the denominator
  always_ff @(posedge clk) begin
    if (ld.s3) begin
      d_r  <= DEN_BITS'(DEN) - a_r;
      v3_r <= v2_r;
    end
  end

  // stage 4: numerator with rounding offset
  always_ff @(posedge clk) begin
    if (ld.s4) begin
      x_r <= X_BITS'(v3_r) * X_BITS'(d_r) + ofs;
    end
  end

  // stage 5: quotient estimate by reciprocal
  assign prod = PROD_BITS'(x_r) * PROD_BITS'(RECIP);

  always_ff @(posedge clk) begin
    if (ld.s5) begin
      q5_r <= prod[X_BITS +: CHANNEL_BITS];
      x5_r <= x_r;
    end
  end

  // stage 6: back-multiply the estimate
  always_ff @(posedge clk) begin
    if (ld.s6) begin
      qd_r <= X_BITS'(q5_r) * X_BITS'(DEN);
      q6_r <= q5_r;
      x6_r <= x5_r;
    end
  end

  // correction: the estimate is low by at most one
  always_comb begin
    diff  = x6_r - qd_r;
    level = (diff >= X_BITS'(DEN)) ? q6_r + CHANNEL_BITS'(1) : q6_r;
  end

endmodule
`default_nettype wire

// ===== rtl/hsv_to_rgb_converter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_unit
// Streaming hsv to rgb color converter, one color per clock while the output side accepts.
// ----------------------------------------------------------------------------
// The converter takes one request per clock when the output side is not
// stalled, and each request passes through the stages in order: one
// stage splits the hue into sector and remainder, five stages run three
// identical level lanes (p, q, t) through multiply, subtract, reciprocal
// divide and back-multiply, and the output register applies the rounding
// correction and the sector's channel order. The longest paths are the
// constant-reciprocal multiply and the back-multiply. Every stage has its
// own valid bit and only stalls when the stage after it is full, so bubbles
// are squeezed out and a new request is taken while a result waits.
// A hue of exactly 360 degrees (23040) is treated as 0; any larger hue
// returns black.
module hsv_to_rgb_converter_unit
  import hsv2rgb_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  // hue[14:0], saturation[22:15], brightness[30:23], zero padding
  input  wire logic [IN_TDATA_BITS-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  // red[7:0], green[15:8], blue[23:16]
  output logic [OUT_TDATA_BITS-1:0]      out_tdata
);

  localparam int LAST = 6;

  logic [LAST:1]           valid_r;
  logic [LAST+1:1]         ld;
  hsv2rgb_ctl_t            ctl1;
  hsv2rgb_ctl_t            ctl_r [2:LAST];
  logic [REM_BITS-1:0]     rem1;
  logic [CHANNEL_BITS-1:0] sat1;
  hsv2rgb_ld_t             lane_ld;
  logic [W_BITS-1:0]       w_q;
  logic [W_BITS-1:0]       w_t;
  logic [CHANNEL_BITS-1:0] lvl_p;
  logic [CHANNEL_BITS-1:0] lvl_q;
  logic [CHANNEL_BITS-1:0] lvl_t;
  logic [CHANNEL_BITS-1:0] red_nxt;
  logic [CHANNEL_BITS-1:0] green_nxt;
  logic [CHANNEL_BITS-1:0] blue_nxt;
  logic [CHANNEL_BITS-1:0] red_r;
  logic [CHANNEL_BITS-1:0] green_r;
  logic [CHANNEL_BITS-1:0] blue_r;
  logic                    out_valid_r;

  // per-stage load: a stage moves when empty or when the next one moves
  always_comb begin
    ld[LAST+1] = !out_valid_r || out_tready;
    for (int k = LAST; k >= 1; k--) begin
      ld[k] = !valid_r[k] || ld[k+1];
    end
  end

  assign in_tready = ld[1];

  always_comb begin
    lane_ld.s2 = ld[2];
    lane_ld.s3 = ld[3];
    lane_ld.s4 = ld[4];
    lane_ld.s5 = ld[5];
    lane_ld.s6 = ld[6];
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld[1]) begin
        valid_r[1] <= in_tvalid;
      end
      for (int k = 2; k <= LAST; k++) begin
        if (ld[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
      if (ld[LAST+1]) begin
        out_valid_r <= valid_r[LAST];
      end
    end
  end

  // stage 1: sector split
  hsv2rgb_sector u_sector (
    .clk   (clk),
    .ld    (ld[1]),
    .hue   (in_tdata[0 +: HUE_BITS]),
    .sat   (in_tdata[HUE_BITS +: CHANNEL_BITS]),
    .bri   (in_tdata[HUE_BITS + CHANNEL_BITS +: CHANNEL_BITS]),
    .ctl_r (ctl1),
    .rem_r (rem1),
    .sat_r (sat1)
  );

  // control delay line beside the lanes
  always_ff @(posedge clk) begin
    if (ld[2]) begin
      ctl_r[2] <= ctl1;
    end
    for (int k = 3; k <= LAST; k++) begin
      if (ld[k]) begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  // hue weights for q and t
  assign w_q = W_BITS'(rem1);
  assign w_t = W_BITS'(HUE_SECTOR) - W_BITS'(rem1);

  hsv2rgb_level u_level_p (
    .clk    (clk),
    .ld     (lane_ld),
    .sat    (sat1),
    .bri    (ctl1.bri),
    .weight (W_BITS'(HUE_SECTOR)),
    .ofs    (X_BITS'(P_OFS)),
    .level  (lvl_p)
  );

  hsv2rgb_level u_level_q (
    .clk    (clk),
    .ld     (lane_ld),
    .sat    (sat1),
    .bri    (ctl1.bri),
    .weight (w_q),
    .ofs    (X_BITS'(QT_OFS)),
    .level  (lvl_q)
  );

  hsv2rgb_level u_level_t (
    .clk    (clk),
    .ld     (lane_ld),
    .sat    (sat1),
    .bri    (ctl1.bri),
    .weight (w_t),
    .ofs    (X_BITS'(QT_OFS)),
    .level  (lvl_t)
  );

  // channel order by sector
  always_comb begin
    red_nxt   = '0;
    green_nxt = '0;
    blue_nxt  = '0;
    if (!ctl_r[LAST].black) begin
      case (ctl_r[LAST].sector)
        SEC_RED: begin
          red_nxt = ctl_r[LAST].bri; green_nxt = lvl_t; blue_nxt = lvl_p;
        end
        SEC_YELLOW: begin
          red_nxt = lvl_q; green_nxt = ctl_r[LAST].bri; blue_nxt = lvl_p;
        end
        SEC_GREEN: begin
          red_nxt = lvl_p; green_nxt = ctl_r[LAST].bri; blue_nxt = lvl_t;
        end
        SEC_CYAN: begin
          red_nxt = lvl_p; green_nxt = lvl_q; blue_nxt = ctl_r[LAST].bri;
        end
        SEC_BLUE: begin
          red_nxt = lvl_t; green_nxt = lvl_p; blue_nxt = ctl_r[LAST].bri;
        end
        default: begin
          red_nxt = ctl_r[LAST].bri; green_nxt = lvl_p; blue_nxt = lvl_q;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (ld[LAST+1] && valid_r[LAST]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  always_comb begin
    out_tdata                                     = '0;
    out_tdata[0 +: CHANNEL_BITS]                  = red_r;
    out_tdata[CHANNEL_BITS +: CHANNEL_BITS]       = green_r;
    out_tdata[2 * CHANNEL_BITS +: CHANNEL_BITS]   = blue_r;
  end

  // input only backs up when the output is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled while output side is free");

  // input only backs up when every stage is full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&valid_r))
    else $error("input stalled with a bubble in the pipeline");

  // a result only appears from a filled last stage
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(valid_r[LAST]))
    else $error("result appeared without a request in the last stage");

endmodule
`default_nettype wire

// ===== tb/hsv_to_rgb_converter_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_unit_test
// Drives hue, saturation and value requests into the converter over its input
// stream and checks every rgb result against an integer model of the
// conversion. The run covers the hue extremes, every sector, the full-turn
// wrap and the black range beyond it, with random gaps and stalls on both
// sides, one stretch without any, and one long output hold-off.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_unit_test;
  import hsv2rgb_pkg::*;

  localparam int  RANDOM_REQS   = 2000;
  localparam int  CYCLE_LIMIT   = 200000;
  localparam int  DRAIN_CYCLES  = 20;
  localparam int  IDLE_PCT      = 26;
  localparam int  QUIET_FIRST   = 1000;
  localparam int  QUIET_LAST    = 1400;
  localparam int  HOLD_AT       = 300;
  localparam int  HOLD_CYCLES   = 250;
  localparam int  MAX_PRINTS    = 30;
  localparam int  HUE_TOP       = (1 << HUE_BITS) - 1;
  localparam int  CHAN_TOP      = (1 << CHANNEL_BITS) - 1;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] blue;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] red;
  } rgb_t;

  typedef struct {
    logic [HUE_BITS-1:0]     hue;
    logic [CHANNEL_BITS-1:0] sat;
    logic [CHANNEL_BITS-1:0] bri;
    rgb_t                    rgb;
  } rgb_due_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [IN_TDATA_BITS-1:0]  in_tdata = '0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] out_tdata;

  logic [IN_TDATA_BITS-1:0]  hsv_req_q[$];
  rgb_due_t                  rgb_due_q[$];
  int                        req_sent = 0;
  int                        rgb_seen = 0;
  int                        mismatch_cnt = 0;
  int                        black_reqs = 0;
  int                        wrap_reqs = 0;
  int                        hold_left = 0;
  logic                      hold_done = 1'b0;
  int                        cycle_cnt = 0;

  hsv_to_rgb_converter_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock, 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // integer hsv to rgb conversion, every level rounded to nearest, ties up
  function automatic rgb_t convert_hsv(logic [HUE_BITS-1:0] hue,
                                       logic [CHANNEL_BITS-1:0] sat,
                                       logic [CHANNEL_BITS-1:0] bri);
    longint unsigned h, s, v, den, rem, lvl_p, lvl_q, lvl_t;
    hsv2rgb_sec_t    sec;
    rgb_t            c;
    h = hue;
    s = sat;
    v = bri;
    c = '0;
    // a full turn wraps to red, anything past it stays black
    if (h == HUE_FULL) h = 0;
    if (h < HUE_FULL) begin
      sec   = hsv2rgb_sec_t'(3'(h / HUE_SECTOR));
      rem   = h % HUE_SECTOR;
      den   = CHAN_MAX * HUE_SECTOR;
      lvl_p = (v * (CHAN_MAX - s) + CHAN_MAX / 2) / CHAN_MAX;
      lvl_q = (v * (den - s * rem) + den / 2) / den;
      lvl_t = (v * (den - s * (HUE_SECTOR - rem)) + den / 2) / den;
      case (sec)
        SEC_RED: begin
          c.red = CHANNEL_BITS'(v); c.green = CHANNEL_BITS'(lvl_t); c.blue = CHANNEL_BITS'(lvl_p);
        end
        SEC_YELLOW: begin
          c.red = CHANNEL_BITS'(lvl_q); c.green = CHANNEL_BITS'(v); c.blue = CHANNEL_BITS'(lvl_p);
        end
        SEC_GREEN: begin
          c.red = CHANNEL_BITS'(lvl_p); c.green = CHANNEL_BITS'(v); c.blue = CHANNEL_BITS'(lvl_t);
        end
        SEC_CYAN: begin
          c.red = CHANNEL_BITS'(lvl_p); c.green = CHANNEL_BITS'(lvl_q); c.blue = CHANNEL_BITS'(v);
        end
        SEC_BLUE: begin
          c.red = CHANNEL_BITS'(lvl_t); c.green = CHANNEL_BITS'(lvl_p); c.blue = CHANNEL_BITS'(v);
        end
        default: begin
          c.red = CHANNEL_BITS'(v); c.green = CHANNEL_BITS'(lvl_p); c.blue = CHANNEL_BITS'(lvl_q);
        end
      endcase
    end
    return c;
  endfunction

  // one line per wrong channel, printing capped to keep the log short
  task automatic report_mismatch(string chan, rgb_due_t due, int got, int want);
    if (mismatch_cnt < MAX_PRINTS)
      $display("mismatch at result %0d: %s got %0d want %0d (hue %0d sat %0d val %0d)",
               rgb_seen, chan, got, want, due.hue, due.sat, due.bri);
    mismatch_cnt++;
  endtask

  task automatic queue_hsv(int hue, int sat, int bri);
    logic [IN_TDATA_BITS-1:0] word;
    word = '0;
    word[HUE_BITS-1:0] = HUE_BITS'(hue);
    word[HUE_BITS +: CHANNEL_BITS] = CHANNEL_BITS'(sat);
    word[HUE_BITS+CHANNEL_BITS +: CHANNEL_BITS] = CHANNEL_BITS'(bri);
    hsv_req_q.push_back(word);
  endtask

  function automatic int pick_level();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return 0;
    if (sel < 20) return CHAN_TOP;
    return $urandom_range(CHAN_TOP);
  endfunction

  // request driver: offers queued colors, keeps the current one until taken
  always @(posedge clk) begin
    logic [HUE_BITS-1:0]     a_hue;
    logic [CHANNEL_BITS-1:0] a_sat, a_bri;
    rgb_due_t                due;
    logic                    quiet, idle;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        a_hue = in_tdata[HUE_BITS-1:0];
        a_sat = in_tdata[HUE_BITS +: CHANNEL_BITS];
        a_bri = in_tdata[HUE_BITS+CHANNEL_BITS +: CHANNEL_BITS];
        due.hue = a_hue;
        due.sat = a_sat;
        due.bri = a_bri;
        due.rgb = convert_hsv(a_hue, a_sat, a_bri);
        rgb_due_q.push_back(due);
        if (a_hue > HUE_FULL) black_reqs++;
        if (a_hue == HUE_FULL) wrap_reqs++;
        req_sent <= req_sent + 1;
      end
      if (!in_tvalid || in_tready) begin
        quiet = (req_sent >= QUIET_FIRST) && (req_sent < QUIET_LAST);
        idle  = !quiet && ($urandom_range(99) < IDLE_PCT);
        if (hsv_req_q.size() != 0 && !idle) begin
          in_tdata  <= hsv_req_q.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long output hold-off so the pipeline fills and backs up the input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && rgb_seen >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor: compare each taken color with the oldest expectation
  always @(posedge clk) begin
    rgb_t     got;
    rgb_due_t due;
    logic     quiet;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = rgb_t'(out_tdata[3*CHANNEL_BITS-1:0]);
        if (rgb_due_q.size() == 0) begin
          if (mismatch_cnt < MAX_PRINTS)
            $display("unexpected result %0d: rgb %0d %0d %0d",
                     rgb_seen, got.red, got.green, got.blue);
          mismatch_cnt++;
        end else begin
          due = rgb_due_q.pop_front();
          if (got.red !== due.rgb.red)
            report_mismatch("red", due, got.red, due.rgb.red);
          if (got.green !== due.rgb.green)
            report_mismatch("green", due, got.green, due.rgb.green);
          if (got.blue !== due.rgb.blue)
            report_mismatch("blue", due, got.blue, due.rgb.blue);
        end
        rgb_seen <= rgb_seen + 1;
      end
      quiet = (rgb_seen >= QUIET_FIRST) && (rgb_seen < QUIET_LAST);
      out_tready <= (hold_left == 0) && (quiet || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, rgb_due_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int sel, hue;
    // extremes of the fields
    queue_hsv(0, CHAN_TOP, CHAN_TOP);
    queue_hsv(0, 0, CHAN_TOP);
    queue_hsv(0, CHAN_TOP, 0);
    queue_hsv(1, 1, 1);
    queue_hsv(HUE_TOP, CHAN_TOP, CHAN_TOP);
    queue_hsv(16383, 85, 170);
    // full turn wraps to red, just past it is black, just short is magenta
    queue_hsv(HUE_FULL, CHAN_TOP, CHAN_TOP);
    queue_hsv(HUE_FULL + 1, CHAN_TOP, CHAN_TOP);
    queue_hsv(HUE_FULL - 1, CHAN_TOP, CHAN_TOP);
    // middle of every sector and the last hue before each boundary
    for (int k = 0; k < SECTORS; k++)
      queue_hsv(k * HUE_SECTOR + HUE_SECTOR / 2, 128, CHAN_TOP);
    for (int k = 1; k < SECTORS; k++)
      queue_hsv(k * HUE_SECTOR - 1, CHAN_TOP, 200);
    queue_hsv(HUE_SECTOR - 1, CHAN_TOP, CHAN_TOP);
    queue_hsv(3 * HUE_SECTOR, 127, 128);

    // random colors, weighted toward the valid hue range and sector edges
    for (int i = 0; i < RANDOM_REQS; i++) begin
      sel = $urandom_range(99);
      if (sel < 78)
        hue = $urandom_range(HUE_FULL - 1);
      else if (sel < 83)
        hue = HUE_FULL;
      else if (sel < 91)
        hue = $urandom_range(HUE_TOP, HUE_FULL + 1);
      else
        hue = $urandom_range(SECTORS, 1) * HUE_SECTOR - $urandom_range(1);
      queue_hsv(hue, pick_level(), pick_level());
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (hsv_req_q.size() != 0 || in_tvalid) @(posedge clk);
    while (rgb_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d colors, %0d past a full turn and %0d at exactly 360 degrees,",
             req_sent, black_reqs, wrap_reqs);
    $display("%0d results checked with random stalls and one %0d-cycle output hold-off",
             rgb_seen, HOLD_CYCLES);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== hsv_to_rgb_converter_unit.f =====
rtl/hsv2rgb_pkg.sv
rtl/hsv2rgb_sector.sv
rtl/hsv2rgb_level.sv
rtl/hsv_to_rgb_converter_unit.sv
tb/hsv_to_rgb_converter_unit_test.sv
